// ===== rtl/gnb_pkg.sv =====
// gnb_pkg: shared widths, constants, codes and link structs for the
// gaussian naive bayes classifier; no dependencies
`timescale 1ns / 1ps

package gnb_pkg;

  localparam int OP_W       = 2;
  localparam int CLS_W      = 6;
  localparam int FEAT_W     = 12;
  localparam int PRIOR_W    = 17;
  localparam int VAL_W      = 32;
  localparam int VAR_W      = 31;
  localparam int EPS_W      = 31;
  localparam int CU_W       = 7;
  localparam int FU_W       = 13;
  localparam int SCORE_W    = 48;
  localparam int SCALE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [EPS_W-1:0] EPS_RESET = 31'd3277;
  localparam logic [CU_W-1:0]  CU_RESET  = 7'd26;
  localparam logic [FU_W-1:0]  FU_RESET  = 13'd784;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 48'sh8000_0000_0000;

  // ln(2) in Q0.32, 2*pi in Q3.29
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  typedef enum logic [OP_W-1:0] {
    OP_PRIOR   = 2'd0,
    OP_MEANVAR = 2'd1,
    OP_SAMPLE  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPSILON  = 2'd0,
    REG_CLASSES  = 2'd1,
    REG_FEATURES = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CALC,
    ST_ISSUE,
    ST_FLUSH,
    ST_FIRE,
    ST_TOKEN,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_NORM,
    LN_SQUARE,
    LN_MAG,
    LN_MUL
  } ln_state_t;

  // command walking down the class chain
  typedef struct packed {
    logic                       valid;
    op_t                        op;
    logic [CLS_W-1:0]           class_index;
    logic [FEAT_W-1:0]          feature_index;
    logic signed [VAL_W-1:0]    value;
    logic [SCALE_W-1:0]         scale;
    logic signed [SCORE_W-1:0]  bias_term;
  } cell_cmd_t;

  // running argmax token
  typedef struct packed {
    logic                       valid;
    logic [CLS_W-1:0]           class_index;
    logic signed [SCORE_W-1:0]  score;
  } best_tok_t;

endpackage

// ===== rtl/gnb_if.sv =====
// gnb_if: valid/ready channel interfaces for items, results and register writes
// depends on gnb_pkg
`timescale 1ns / 1ps

interface gnb_item_if;
  import gnb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [CLS_W-1:0]        class_index;
  logic [FEAT_W-1:0]       feature_index;
  logic [PRIOR_W-1:0]      prior_value;
  logic signed [VAL_W-1:0] mean_value;
  logic [VAR_W-1:0]        variance_value;
  logic signed [VAL_W-1:0] feature_value;
  logic                    last_feature;

  modport source (output valid, op, class_index, feature_index, prior_value, mean_value,
                  variance_value, feature_value, last_feature, input ready);
  modport sink (input valid, op, class_index, feature_index, prior_value, mean_value,
                variance_value, feature_value, last_feature, output ready);
endinterface

interface gnb_result_if;
  import gnb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CLS_W-1:0]          predicted_class;
  logic signed [SCORE_W-1:0] best_score;

  modport source (output valid, predicted_class, best_score, input ready);
  modport sink (input valid, predicted_class, best_score, output ready);
endinterface

interface gnb_cfg_if;
  import gnb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gnb_ram.sv =====
// gnb_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module gnb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 784,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gnb_log.sv =====
// gnb_log: sequential natural log, normalize one bit a cycle, 16 squaring steps,
// then scale by ln2; depends on gnb_pkg
`timescale 1ns / 1ps

module gnb_log (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [63:0]                        v,
  input  logic                               mv,
  output logic                               busy,
  output logic signed [gnb_pkg::SCORE_W-1:0] result
);
  import gnb_pkg::*;

  ln_state_t state, state_next;

  logic [63:0]        norm;
  logic [5:0]         p;
  logic [31:0]        m;
  logic [15:0]        frac;
  logic [3:0]         step;
  logic               mv_q;
  logic [23:0]        mag;
  logic               neg;
  logic [63:0]        sq;
  logic [32:0]        sq_top;
  logic signed [7:0]  ipart;
  logic signed [23:0] l2;
  logic [55:0]        prod;
  logic [23:0]        shifted;
  logic [SCORE_W-1:0] res_mag;

  assign busy    = (state != LN_IDLE);
  assign sq      = 64'(m) * 64'(m);
  assign sq_top  = sq[63:31];
  // mean/variance path carries 45 fraction bits and is halved
  assign ipart   = $signed({2'b00, p}) - (mv_q ? 8'sd45 : 8'sd16);
  assign l2      = {ipart, frac};
  assign prod    = 56'(mag) * 56'(LN2_Q32);
  assign shifted = mv_q ? {1'b0, prod[55:33]} : prod[55:32];
  assign res_mag = SCORE_W'(shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      LN_IDLE:   if (start) state_next = LN_NORM;
      LN_NORM:   if (norm[63]) state_next = LN_SQUARE;
      LN_SQUARE: if (step == 4'd15) state_next = LN_MAG;
      LN_MAG:    state_next = LN_MUL;
      LN_MUL:    state_next = LN_IDLE;
      default:   state_next = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      LN_IDLE: begin
        if (start) begin
          norm <= (v == '0) ? 64'd1 : v;
          p    <= 6'd63;
          mv_q <= mv;
        end
      end
      LN_NORM: begin
        if (!norm[63]) begin
          norm <= norm << 1;
          p    <= p - 6'd1;
        end else begin
          m    <= norm[63:32];
          frac <= '0;
          step <= '0;
        end
      end
      LN_SQUARE: begin
        if (sq_top[32]) begin
          m          <= sq_top[32:1];
          frac[~step] <= 1'b1;
        end else begin
          m <= sq_top[31:0];
        end
        step <= step + 4'd1;
      end
      LN_MAG: begin
        mag <= l2[23] ? 24'(-l2) : 24'(l2);
        neg <= l2[23];
      end
      LN_MUL: begin
        result <= neg ? -$signed(res_mag) : $signed(res_mag);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gnb_div.sv =====
// gnb_div: restoring divider, 2^39 over a 32-bit divisor, one quotient bit a
// cycle, quotient saturated to 32 bits; depends on gnb_pkg
`timescale 1ns / 1ps

module gnb_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [31:0]                        divisor,
  output logic                               busy,
  output logic [gnb_pkg::SCALE_W-1:0]        scale
);
  import gnb_pkg::*;

  localparam int STEPS = 40;

  logic [31:0]      den;
  logic [31:0]      rem;
  logic [STEPS-1:0] quo;
  logic [5:0]       cnt;
  logic [32:0]      trial;
  logic             fits;

  // dividend is a single one at the top bit
  assign trial = {rem, cnt == 6'(STEPS)};
  assign fits  = trial >= {1'b0, den};
  assign scale = (quo[STEPS-1:SCALE_W] != '0) ? '1 : quo[SCALE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy && start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'd1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      den <= divisor;
      rem <= '0;
      quo <= '0;
      cnt <= 6'(STEPS);
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
      quo <= {quo[STEPS-2:0], fits};
      cnt <= cnt - 6'd1;
    end
  end

endmodule

// ===== rtl/gnb_cell.sv =====
// gnb_cell: one class of the chain; holds its mean/scale ram, bias and score,
// scores samples in a short pipeline and folds in the argmax token; needs gnb_pkg, gnb_ram
`timescale 1ns / 1ps

module gnb_cell #(
  parameter int NUM_FEATURES = 784,
  parameter int IDX = 0,
  localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [gnb_pkg::CU_W-1:0]     cu,
  input  gnb_pkg::cell_cmd_t           cmd_in,
  output gnb_pkg::cell_cmd_t           cmd_out,
  input  gnb_pkg::best_tok_t           tok_in,
  output gnb_pkg::best_tok_t           tok_out
);
  import gnb_pkg::*;

  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SCORE_W:0] x);
    if (x[SCORE_W] != x[SCORE_W-1]) begin
      return x[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
    return x[SCORE_W-1:0];
  endfunction

  logic                      mine;
  logic                      in_use;
  logic                      wr_en;
  logic [VAL_W+SCALE_W-1:0]  rdata;
  logic signed [VAL_W-1:0]   mean;
  logic signed [VAL_W:0]     diff;
  logic [VAL_W-1:0]          ad;
  logic [64:0]               sum;
  logic signed [SCORE_W-1:0] bias;
  logic signed [SCORE_W-1:0] score;
  logic signed [SCORE_W-1:0] total;
  logic                      take;

  logic                      s1_v, s2_v, s3_v, s4_v, s5_v;
  logic signed [VAL_W-1:0]   s1_x;
  logic [VAL_W-1:0]          s2_ad;
  logic [SCALE_W-1:0]        s2_sc, s3_sc;
  logic [63:0]               s3_sq;
  logic [63:0]               s4_hi, s4_lo;
  logic [SCORE_W-2:0]        s5_term;

  assign mine   = cmd_in.class_index == CLS_W'(IDX);
  assign in_use = CU_W'(IDX) < cu;
  assign wr_en  = cmd_in.valid && cmd_in.op == OP_MEANVAR && mine;

  gnb_ram #(.WIDTH(VAL_W + SCALE_W), .DEPTH(NUM_FEATURES)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cmd_in.feature_index[AW-1:0]),
    .wdata ({cmd_in.value, cmd_in.scale}),
    .raddr (cmd_in.feature_index[AW-1:0]),
    .rdata (rdata)
  );

  assign mean  = rdata[VAL_W+SCALE_W-1:SCALE_W];
  assign diff  = $signed({s1_x[VAL_W-1], s1_x}) - $signed({mean[VAL_W-1], mean});
  assign ad    = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
  assign sum   = {1'b0, s4_hi} + 65'(s4_lo[63:32]);
  assign total = sat_score($signed({bias[SCORE_W-1], bias}) + $signed({score[SCORE_W-1], score}));
  assign take  = (IDX == 0) || (in_use && $signed(total) > $signed(tok_in.score));

  // chain links
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out <= '0;
      tok_out <= '0;
    end else begin
      cmd_out <= cmd_in;
      tok_out <= take ? best_tok_t'{tok_in.valid, CLS_W'(IDX), total} : tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.valid && mine) begin
      if (cmd_in.op == OP_PRIOR) begin
        bias <= cmd_in.bias_term;
      end else if (cmd_in.op == OP_MEANVAR) begin
        bias <= sat_score($signed({bias[SCORE_W-1], bias})
                        - $signed({cmd_in.bias_term[SCORE_W-1], cmd_in.bias_term}));
      end
    end
  end

  // sample pipeline: ram read, |x-mean|, square, times scale, sum and cap
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      s1_v <= cmd_in.valid && cmd_in.op == OP_SAMPLE && in_use;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_x    <= cmd_in.value;
    s2_ad   <= ad;
    s2_sc   <= rdata[SCALE_W-1:0];
    s3_sq   <= 64'(s2_ad) * 64'(s2_ad);
    s3_sc   <= s2_sc;
    s4_hi   <= 64'(s3_sq[63:32]) * 64'(s3_sc);
    s4_lo   <= 64'(s3_sq[31:0]) * 64'(s3_sc);
    s5_term <= (sum[64:55] != '0) ? '1 : sum[54:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
    end else if (tok_in.valid) begin
      score <= '0;
    end else if (s5_v) begin
      score <= sat_score($signed({score[SCORE_W-1], score}) - $signed({2'b00, s5_term}));
    end
  end

endmodule

// ===== rtl/gaussian_naive_bayes_classify.sv =====
// gaussian naive bayes classifier: one item at a time; after a sample the next item is taken
// once the class chain has drained, a last sample first runs the argmax walk; a prior or
// mean/variance load first waits on the one-bit-a-cycle log normalizer and the 40-step
// divider; a result sits in an output register while the next item enters; reset restores
// epsilon, classes and features to defaults and clears all class scores; mean/scale rams
// and biases undefined until loaded
`timescale 1ns / 1ps

module gaussian_naive_bayes_classify #(
  parameter int NUM_CLASSES  = 26,
  parameter int NUM_FEATURES = 784
) (
  input logic         clk,
  input logic         rst,
  gnb_item_if.sink    item,
  gnb_result_if.source result,
  gnb_cfg_if.sink     cfg
);
  import gnb_pkg::*;

  // cycles after a command enters the chain until the last cell's pipeline drained
  localparam int WAIT  = NUM_CLASSES + 6;
  localparam int CNT_W = $clog2(WAIT + 1);
  localparam logic [CU_W-1:0] CU_MAX = CU_W'(NUM_CLASSES);

  ctl_state_t state, state_next;

  // configuration registers
  logic [EPS_W-1:0] eps;
  logic [CU_W-1:0]  cu_reg;
  logic [CU_W-1:0]  cu_eff;
  logic [FU_W-1:0]  fu_reg;

  // item held while it is worked on
  op_t                     h_op;
  logic [CLS_W-1:0]        h_class;
  logic [FEAT_W-1:0]       h_feat;
  logic signed [VAL_W-1:0] h_value;
  logic [PRIOR_W-1:0]      h_prior;
  logic [31:0]             h_s;
  logic                    h_last;
  logic                    h_hit;

  logic [CNT_W-1:0] cnt;
  logic             in_fire;
  logic             cfg_fire;
  logic             feat_ok;
  logic             in_hit;
  logic [31:0]      s_sum;
  logic             ln_start;
  logic             ln_busy;
  logic             div_busy;
  logic [63:0]      ln_v;
  logic signed [SCORE_W-1:0] ln_res;
  logic [SCALE_W-1:0]        div_q;
  logic             out_load;

  // argmax winner and output register
  logic [CLS_W-1:0]          win_class;
  logic signed [SCORE_W-1:0] win_score;
  logic                      out_valid;
  logic [CLS_W-1:0]          out_class;
  logic signed [SCORE_W-1:0] out_score;

  cell_cmd_t cmd_link [NUM_CLASSES+1];
  best_tok_t tok_link [NUM_CLASSES+1];
  best_tok_t tok_end;

  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign in_fire    = item.valid && item.ready;
  assign cfg_fire   = cfg.valid && cfg.ready;

  assign result.valid           = out_valid;
  assign result.predicted_class = out_class;
  assign result.best_score      = out_score;

  // classes in use: zero acts as one, clipped to the built class count
  assign cu_eff = (cu_reg == '0) ? CU_W'(1) : ((cu_reg > CU_MAX) ? CU_MAX : cu_reg);

  assign feat_ok = FU_W'(item.feature_index) < FU_W'(NUM_FEATURES);
  // smoothed variance, zero taken as one
  assign s_sum   = {1'b0, item.variance_value} + {1'b0, eps};

  always_comb begin
    unique case (item.op)
      OP_PRIOR:   in_hit = 1'b1;
      OP_MEANVAR: in_hit = feat_ok;
      OP_SAMPLE:  in_hit = feat_ok && (FU_W'(item.feature_index) < fu_reg);
      default:    in_hit = 1'b0;
    endcase
  end

  // log argument: the prior itself, or 2*pi*s with 45 fraction bits
  assign ln_v = (h_op == OP_PRIOR) ? 64'(h_prior) : 64'(h_s) * 64'(TWO_PI_Q29);

  gnb_log u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (ln_start),
    .v      (ln_v),
    .mv     (h_op == OP_MEANVAR),
    .busy   (ln_busy),
    .result (ln_res)
  );

  gnb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (ln_start),
    .divisor (h_s),
    .busy    (div_busy),
    .scale   (div_q)
  );

  // command and argmax token entering the first cell
  assign cmd_link[0] = '{
    valid:         (state == ST_ISSUE) && h_hit,
    op:            h_op,
    class_index:   h_class,
    feature_index: h_feat,
    value:         h_value,
    scale:         div_q,
    bias_term:     (h_op == OP_PRIOR && h_prior == '0) ? SCORE_MIN : ln_res
  };
  assign tok_link[0] = '{valid: (state == ST_FIRE), class_index: '0, score: SCORE_MIN};
  assign tok_end     = tok_link[NUM_CLASSES];

  // row of class cells, command and token both step one cell a cycle
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cell
    gnb_cell #(.NUM_FEATURES(NUM_FEATURES), .IDX(c)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cu      (cu_eff),
      .cmd_in  (cmd_link[c]),
      .cmd_out (cmd_link[c+1]),
      .tok_in  (tok_link[c]),
      .tok_out (tok_link[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ln_start   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (item.op)
            OP_PRIOR:   state_next = ST_PREP;
            OP_MEANVAR: state_next = in_hit ? ST_PREP : ST_IDLE;
            OP_SAMPLE:  state_next = ST_ISSUE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PREP: begin
        ln_start   = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        if (!ln_busy && !div_busy) state_next = ST_ISSUE;
      end
      ST_ISSUE: state_next = ST_FLUSH;
      ST_FLUSH: begin
        if (cnt == '0) state_next = (h_op == OP_SAMPLE && h_last) ? ST_FIRE : ST_IDLE;
      end
      ST_FIRE: state_next = ST_TOKEN;
      ST_TOKEN: begin
        if (tok_end.valid) state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eps    <= EPS_RESET;
      cu_reg <= CU_RESET;
      fu_reg <= FU_RESET;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_EPSILON:  eps    <= cfg.data[EPS_W-1:0];
        REG_CLASSES:  cu_reg <= cfg.data[CU_W-1:0];
        REG_FEATURES: fu_reg <= cfg.data[FU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      h_op    <= op_t'(item.op);
      h_class <= item.class_index;
      h_feat  <= item.feature_index;
      h_value <= (item.op == OP_SAMPLE) ? item.feature_value : item.mean_value;
      h_prior <= item.prior_value;
      h_s     <= (s_sum == '0) ? 32'd1 : s_sum;
      h_last  <= item.last_feature;
      h_hit   <= in_hit;
    end
    if (state == ST_TOKEN && tok_end.valid) begin
      win_class <= tok_end.class_index;
      win_score <= tok_end.score;
    end
    if (out_load) begin
      out_class <= win_class;
      out_score <= win_score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_ISSUE) begin
      cnt <= CNT_W'(WAIT);
    end else if (state == ST_FLUSH && cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/gnb_checker.sv =====
// gnb_checker: port-level assertions for the classifier, bound to the top level
// depends on gnb_pkg and gaussian_naive_bayes_classify
`timescale 1ns / 1ps

module gnb_checker #(
  parameter int NUM_CLASSES = 26
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic [gnb_pkg::CLS_W-1:0]          predicted_class,
  input logic signed [gnb_pkg::SCORE_W-1:0] best_score
);
  import gnb_pkg::*;

  // a result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(predicted_class) && $stable(best_score))
    else $error("stalled result beat changed");

  // a new result only appears after the block was busy with the argmax walk
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared while input side was idle");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, predicted_class} < (CLS_W + 1)'(NUM_CLASSES)))
    else $error("predicted class beyond built classes");

endmodule

bind gaussian_naive_bayes_classify gnb_checker #(.NUM_CLASSES(NUM_CLASSES)) u_gnb_checker (
  .clk             (clk),
  .rst             (rst),
  .item_ready      (item.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .predicted_class (result.predicted_class),
  .best_score      (result.best_score)
);
